[design/hfc_pkg.sv]
// Shared types and constants for the HDLC byte-stuffing framer.
`timescale 1ns / 1ps

package hfc_pkg;

  localparam logic [7:0]  FlagByte = 8'h7E;
  localparam logic [7:0]  EscByte  = 8'h7D;
  localparam logic [7:0]  EscXor   = 8'h20;
  localparam logic [15:0] CrcPoly  = 16'h8408;
  localparam logic [15:0] CrcSeed  = 16'hFFFF;

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  // One classified payload byte, as handed from the front to the back.
  typedef struct packed {
    logic        open_flag;
    logic [7:0]  data;
    logic        last;
    logic [15:0] fcs;
  } hfc_cmd_t;

endpackage

[design/hfc_front.sv]
// Front end: accepts payload bytes, runs the CRC and tracks frame state.
`timescale 1ns / 1ps

module hfc_front import hfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic       fifo_full_i,
  output logic       push_o,
  output hfc_cmd_t   cmd_o
);

  logic [15:0] crc_q, crc_d;
  logic        open_q, open_d;
  logic [15:0] crc_next;

  // Reflected CRC-16 over one byte, a bit per step.
  function automatic logic [15:0] hfc_crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  assign crc_next   = hfc_crc_byte(crc_q, data_byte_i);
  assign in_ready_o = !fifo_full_i;
  assign push_o     = in_valid_i && !fifo_full_i;

  always_comb begin
    cmd_o.open_flag = !open_q;
    cmd_o.data      = data_byte_i;
    cmd_o.last      = last_byte_i;
    cmd_o.fcs       = ~crc_next;
  end

  always_comb begin
    crc_d  = crc_q;
    open_d = open_q;
    if (push_o) begin
      if (last_byte_i) begin
        crc_d  = CrcSeed;
        open_d = 1'b0;
      end else begin
        crc_d  = crc_next;
        open_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q  <= CrcSeed;
      open_q <= 1'b0;
    end else begin
      crc_q  <= crc_d;
      open_q <= open_d;
    end
  end

endmodule

[design/hfc_fifo.sv]
// Short command queue between the front end and the byte sequencer.
`timescale 1ns / 1ps

module hfc_fifo import hfc_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  hfc_cmd_t cmd_i,
  input  logic     pop_i,
  output logic     full_o,
  output logic     empty_o,
  output hfc_cmd_t head_o
);

  hfc_cmd_t              mem_q [FifoDepth];
  logic [FifoPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]   cnt_q, cnt_d;
  logic                  do_pop;

  localparam logic [FifoPtrW-1:0] PtrLast = FifoPtrW'(FifoDepth - 1);
  localparam logic [FifoCntW-1:0] CntFull = FifoCntW'(FifoDepth);

  assign full_o  = (cnt_q == CntFull);
  assign empty_o = (cnt_q == '0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && do_pop) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

[design/hfc_back.sv]
// Back end: walks each queued command and emits the stuffed byte stream.
`timescale 1ns / 1ps

module hfc_back import hfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       head_valid_i,
  input  hfc_cmd_t   head_i,
  output logic       pop_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  typedef enum logic [2:0] {
    StOpen,
    StData,
    StFcsLo,
    StFcsHi,
    StClose
  } step_e;

  step_e      step_q, step_d, step_cur;
  logic       started_q, started_d;
  logic       esc_q, esc_d;
  logic       valid_q, valid_d;
  logic [7:0] byte_q, byte_d;
  logic       rlast_q, rlast_d;
  logic       fend_q, fend_d;
  logic       advance;
  logic       done;
  logic [7:0] src;
  step_e      step_after;

  assign advance  = head_valid_i && (!valid_q || out_ready_i);
  assign step_cur = started_q ? step_q : (head_i.open_flag ? StOpen : StData);

  always_comb begin
    src        = head_i.data;
    step_after = StClose;
    case (step_cur)
      StData: begin
        src        = head_i.data;
        step_after = StFcsLo;
      end
      StFcsLo: begin
        src        = head_i.fcs[7:0];
        step_after = StFcsHi;
      end
      StFcsHi: begin
        src        = head_i.fcs[15:8];
        step_after = StClose;
      end
      default: begin
        src        = head_i.data;
        step_after = StData;
      end
    endcase
  end

  always_comb begin
    step_d    = step_q;
    started_d = started_q;
    esc_d     = esc_q;
    byte_d    = byte_q;
    rlast_d   = rlast_q;
    fend_d    = fend_q;
    valid_d   = valid_q && !out_ready_i;
    done      = 1'b0;
    if (advance) begin
      valid_d = 1'b1;
      fend_d  = 1'b0;
      case (step_cur)
        StOpen: begin
          byte_d = FlagByte;
          step_d = StData;
        end
        StClose: begin
          byte_d = FlagByte;
          fend_d = 1'b1;
          done   = 1'b1;
        end
        default: begin
          if (!esc_q && (src == EscByte || src == FlagByte)) begin
            // First half of an escape pair; the same step repeats for the second.
            byte_d = EscByte;
            esc_d  = 1'b1;
            step_d = step_cur;
          end else begin
            byte_d = esc_q ? (src ^ EscXor) : src;
            esc_d  = 1'b0;
            step_d = step_after;
            done   = (step_cur == StData) && !head_i.last;
          end
        end
      endcase
      rlast_d   = done;
      started_d = !done;
    end
  end

  assign pop_o = advance && done;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= StData;
      started_q <= 1'b0;
      esc_q     <= 1'b0;
      valid_q   <= 1'b0;
      byte_q    <= '0;
      rlast_q   <= 1'b0;
      fend_q    <= 1'b0;
    end else begin
      step_q    <= step_d;
      started_q <= started_d;
      esc_q     <= esc_d;
      valid_q   <= valid_d;
      byte_q    <= byte_d;
      rlast_q   <= rlast_d;
      fend_q    <= fend_d;
    end
  end

  assign out_byte_o  = byte_q;
  assign run_last_o  = rlast_q;
  assign frame_end_o = fend_q;
  assign out_valid_o = valid_q;

endmodule

[design/async_hdlc_framer_crc16.sv]
// Top level of the asynchronous HDLC byte-stuffing framer with CRC-16/X.25.
//
// Input channel: one payload byte per transfer (data_byte_i, last_byte_i),
// handshaked by in_valid_i / in_ready_o. Output channel: one byte of the
// stuffed, framed stream per transfer (out_byte_o, run_last_o, frame_end_o),
// handshaked by out_valid_o / out_ready_i.
// The front end runs the CRC and frame state in the cycle of the input
// transfer and queues a command in a two-entry queue. The back end emits one
// output byte per cycle from the queue head into an output register, while
// the queue holds a command and the receiver is not stalling. The first
// output byte of an item passes through the queue entry and then the output
// register. An item gives one byte for a plain byte, two for an escaped byte
// or a byte that opens a frame, three for an escaped byte that opens a frame,
// and up to eight for a single-byte frame.
// Reset clears the queue, the output register and the frame state, and seeds
// the CRC with all ones. When the receiver stalls, the output register holds;
// the queue keeps accepting until both entries are taken.
`timescale 1ns / 1ps

module async_hdlc_framer_crc16 import hfc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] data_byte_i,
  input  logic       last_byte_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       frame_end_o,
  output logic       out_valid_o,
  input  logic       out_ready_i
);

  hfc_cmd_t push_cmd;
  hfc_cmd_t head_cmd;
  logic     push, pop, full, empty;

  hfc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .fifo_full_i (full),
    .push_o      (push),
    .cmd_o       (push_cmd)
  );

  hfc_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  hfc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!empty),
    .head_i       (head_cmd),
    .pop_o        (pop),
    .out_byte_o   (out_byte_o),
    .run_last_o   (run_last_o),
    .frame_end_o  (frame_end_o),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i)
  );

endmodule

[design/hfc_checker.sv]
// Port-level checker for the framer, bound to the top level.
`timescale 1ns / 1ps

module hfc_checker import hfc_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic [7:0] out_byte_o,
  input logic       run_last_o,
  input logic       frame_end_o,
  input logic       out_valid_o,
  input logic       out_ready_i
);

  // A stalled output holds its byte.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_byte_o))
    else $error("output changed while stalled");

  // The closing flag is a flag byte and ends its item's results.
  a_end_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_end_o |-> out_byte_o == FlagByte && run_last_o)
    else $error("closing flag malformed");

  // An escape byte never ends an item's results.
  a_esc_mid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_byte_o == EscByte |-> !run_last_o)
    else $error("escape byte marked last");

  // The escaped half follows at once after a transferred escape byte.
  a_esc_pair: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_byte_o == EscByte |=>
      out_valid_o && (out_byte_o == (EscByte ^ EscXor) || out_byte_o == (FlagByte ^ EscXor)))
    else $error("escape pair broken");

endmodule

bind async_hdlc_framer_crc16 hfc_checker u_hfc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_byte_o  (out_byte_o),
  .run_last_o  (run_last_o),
  .frame_end_o (frame_end_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

[bench/tb_async_hdlc_framer_crc16.sv]
// Self-checking testbench for the HDLC byte-stuffing framer with CRC-16/X.25.
`timescale 1ns / 1ps

module tb_async_hdlc_framer_crc16;
  import hfc_pkg::*;

  localparam int unsigned CycleLimit = 200000;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } payload_item_t;

  typedef struct packed {
    logic [7:0] val;
    logic       run_last;
    logic       frame_end;
  } wire_item_t;

  logic       clk_i;
  logic       rst_ni = 1'b0;
  logic [7:0] data_byte_i = 8'h00;
  logic       last_byte_i = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] out_byte_o;
  logic       run_last_o;
  logic       frame_end_o;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;

  async_hdlc_framer_crc16 dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .data_byte_i (data_byte_i),
    .last_byte_i (last_byte_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .frame_end_o (frame_end_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  payload_item_t pend_q[$];
  wire_item_t    wire_q[$];
  wire_item_t    want;

  int unsigned payload_sent  = 0;
  int unsigned payload_taken = 0;
  int unsigned err_cnt       = 0;
  int unsigned cyc           = 0;
  int unsigned snd_idle_pct  = 6;
  int unsigned rcv_idle_pct  = 54;
  logic        in_took       = 1'b0;

  // Framer state as the predictor sees it.
  logic [15:0] crc_acc   = CrcSeed;
  logic        frm_open  = 1'b0;

  // Output bytes caused by one payload byte, gathered before they are queued.
  logic [7:0]  stg_val[8];
  logic        stg_end[8];
  int          stg_n;

  function automatic logic [15:0] crc16_x25(input logic [15:0] crc, input logic [7:0] d);
    logic [15:0] c;
    c = crc ^ {8'h00, d};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = (c >> 1) ^ CrcPoly;
      else c = c >> 1;
    end
    return c;
  endfunction

  task automatic stage(input logic [7:0] v, input logic e);
    stg_val[stg_n] = v;
    stg_end[stg_n] = e;
    stg_n++;
  endtask

  task automatic stage_stuffed(input logic [7:0] v);
    if (v == EscByte || v == FlagByte) begin
      stage(EscByte, 1'b0);
      stage(v ^ EscXor, 1'b0);
    end else begin
      stage(v, 1'b0);
    end
  endtask

  // Works out the stuffed stream bytes that one payload transfer produces.
  task automatic frame_payload_byte(input logic [7:0] d, input logic l);
    logic [15:0] fcs;
    wire_item_t  w;
    stg_n = 0;
    if (!frm_open) begin
      stage(FlagByte, 1'b0);
      frm_open = 1'b1;
    end
    crc_acc = crc16_x25(crc_acc, d);
    stage_stuffed(d);
    if (l) begin
      fcs = ~crc_acc;
      stage_stuffed(fcs[7:0]);
      stage_stuffed(fcs[15:8]);
      stage(FlagByte, 1'b1);
      crc_acc  = CrcSeed;
      frm_open = 1'b0;
    end
    for (int i = 0; i < stg_n; i++) begin
      w.val       = stg_val[i];
      w.run_last  = (i == stg_n - 1);
      w.frame_end = stg_end[i];
      wire_q.push_back(w);
    end
  endtask

  task automatic note_mismatch(input string msg);
    $display("ERROR at %0t ns: %s", $time, msg);
    err_cnt++;
  endtask

  task automatic push_item(input logic [7:0] d, input logic l);
    payload_item_t it;
    it.data = d;
    it.last = l;
    pend_q.push_back(it);
    payload_sent++;
  endtask

  // Leans toward the bytes that need stuffing and their unstuffed forms.
  function automatic logic [7:0] pick_byte();
    logic [7:0] v;
    case ($urandom_range(11))
      0: v = FlagByte;
      1: v = EscByte;
      2: v = FlagByte ^ EscXor;
      3: v = EscByte ^ EscXor;
      4: v = $urandom_range(1) ? 8'hFF : 8'h00;
      default: v = 8'($urandom_range(255));
    endcase
    return v;
  endfunction

  // Whole frames only; most are short, a few run long.
  task automatic queue_frames(input int n_items);
    int left;
    int flen;
    left = n_items;
    while (left > 0) begin
      flen = ($urandom_range(9) == 0) ? $urandom_range(24, 9) : $urandom_range(6, 1);
      for (int i = 0; i < flen; i++) push_item(pick_byte(), i == flen - 1);
      left -= flen;
    end
  endtask

  // Sender: a new transfer is offered only once the previous one is taken.
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_took)) begin
      if (pend_q.size() != 0 && $urandom_range(99) >= snd_idle_pct) begin
        in_valid_i  <= 1'b1;
        data_byte_i <= pend_q[0].data;
        last_byte_i <= pend_q[0].last;
        pend_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) out_ready_i <= ($urandom_range(99) >= rcv_idle_pct);
  end

  always @(posedge clk_i) begin
    in_took <= in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      frame_payload_byte(data_byte_i, last_byte_i);
      payload_taken++;
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (wire_q.size() == 0) begin
        note_mismatch($sformatf("output byte %02h with nothing expected", out_byte_o));
      end else begin
        want = wire_q.pop_front();
        if (out_byte_o != want.val)
          note_mismatch($sformatf("out_byte %02h, expected %02h", out_byte_o, want.val));
        if (run_last_o != want.run_last)
          note_mismatch($sformatf("run_last %0b, expected %0b on byte %02h",
                                  run_last_o, want.run_last, want.val));
        if (frame_end_o != want.frame_end)
          note_mismatch($sformatf("frame_end %0b, expected %0b on byte %02h",
                                  frame_end_o, want.frame_end, want.val));
      end
    end
  end

  always @(posedge clk_i) begin
    cyc <= cyc + 1;
    if (cyc == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    logic [15:0] fcs;
    int          hits;
    hits = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Single-byte frames at the extremes and on both special bytes.
    push_item(8'h00, 1'b1);
    push_item(8'hFF, 1'b1);
    push_item(FlagByte, 1'b1);
    push_item(EscByte, 1'b1);
    // A longer frame that mixes stuffed and unstuffed bytes.
    push_item(FlagByte, 1'b0);
    push_item(EscByte, 1'b0);
    push_item(FlagByte ^ EscXor, 1'b0);
    push_item(EscByte ^ EscXor, 1'b0);
    push_item(8'h01, 1'b0);
    push_item(8'h80, 1'b0);
    push_item(8'hAA, 1'b0);
    push_item(8'h55, 1'b1);
    // Single-byte frames whose check sequence itself needs stuffing.
    for (int b = 0; b < 256 && hits < 6; b++) begin
      fcs = ~crc16_x25(CrcSeed, b[7:0]);
      if (fcs[7:0] == FlagByte || fcs[7:0] == EscByte ||
          fcs[15:8] == FlagByte || fcs[15:8] == EscByte) begin
        push_item(b[7:0], 1'b1);
        hits++;
      end
    end
    queue_frames(45);
    while (payload_taken != payload_sent) @(posedge clk_i);

    snd_idle_pct = 54;
    rcv_idle_pct = 6;
    queue_frames(50);
    while (payload_taken != payload_sent) @(posedge clk_i);

    snd_idle_pct = 0;
    rcv_idle_pct = 0;
    queue_frames(50);
    while (payload_taken != payload_sent) @(posedge clk_i);

    while (wire_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[filelist.f]
design/hfc_pkg.sv
design/hfc_front.sv
design/hfc_fifo.sv
design/hfc_back.sv
design/async_hdlc_framer_crc16.sv
design/hfc_checker.sv
bench/tb_async_hdlc_framer_crc16.sv
